@@ rtl/core/ptst_pkg.sv @@
// Package for the per-thread signal table: sizes, request and status codes,
// and the structs that run along the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptst_pkg;

  localparam int ENTRIES = 16;
  localparam int SIG_LAST = 31;

  localparam logic [2:0] REQ_DELIVER   = 3'd0;
  localparam logic [2:0] REQ_BLOCK     = 3'd1;
  localparam logic [2:0] REQ_UNBLOCK   = 3'd2;
  localparam logic [2:0] REQ_SET_MASK  = 3'd3;
  localparam logic [2:0] REQ_READ_MASK = 3'd4;
  localparam logic [2:0] REQ_TAKE      = 3'd5;
  localparam logic [2:0] REQ_READ_PEND = 3'd6;
  localparam logic [2:0] REQ_RELEASE   = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        lookup;
    logic [31:0] lookup_id;
    logic        select;
    logic        claim;
    logic        any_hit;
    logic        wr_en;
    logic [31:0] new_id;
    logic [31:0] new_mask;
    logic [31:0] new_pending;
  } bcast_t;

  // Neighbor-to-neighbor link: running OR of hit, free and selected data.
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [31:0] mask;
    logic [31:0] pending;
  } link_t;

endpackage

`default_nettype wire

@@ rtl/core/ptst_cell.sv @@
// One table entry: thread id, block mask and pending set, with its share of
// the lookup and readout chain. Depends on ptst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptst_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ptst_pkg::bcast_t bc,
  input  wire ptst_pkg::link_t  link_in,
  output ptst_pkg::link_t       link_out,
  output logic                  sel
);
  import ptst_pkg::*;

  logic [31:0] tid;
  logic [31:0] mask;
  logic [31:0] pending;
  logic        hit_q;
  logic        first_free_q;

  logic hit_now;
  logic free_now;
  logic sel_now;

  assign hit_now  = (tid != 32'd0) && (tid == bc.lookup_id);
  assign free_now = (tid == 32'd0);
  // Entry picked: its own hit, or the lowest free entry when nobody hit and the request claims one.
  assign sel_now  = hit_q || (bc.claim && !bc.any_hit && first_free_q);

  always_comb begin
    link_out.hit     = link_in.hit | hit_now;
    link_out.free    = link_in.free | free_now;
    link_out.mask    = link_in.mask | (sel_now ? mask : 32'd0);
    link_out.pending = link_in.pending | (sel_now ? pending : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tid          <= 32'd0;
      mask         <= 32'd0;
      pending      <= 32'd0;
      hit_q        <= 1'b0;
      first_free_q <= 1'b0;
      sel          <= 1'b0;
    end else begin
      if (bc.lookup) begin
        hit_q        <= hit_now;
        first_free_q <= free_now && !link_in.free;
      end
      if (bc.select) begin
        sel <= sel_now;
      end
      if (bc.wr_en && sel) begin
        tid     <= bc.new_id;
        mask    <= bc.new_mask;
        pending <= bc.new_pending;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/per_thread_signal_table_core.sv @@
// Per-thread signal table: request control, result register and the chain of
// entry cells. Depends on ptst_pkg and ptst_cell.
// An accepted transaction passes the id compare on the cell chain, the chained
// readout of the chosen entry (S_READ) and write-back (S_WRITE), which waits
// while the output is stalled and loads the output register; in_stall holds off
// new transactions until write-back. Reset (rst, synchronous) frees all entries
// and clears masks and pending sets; the block accepts a transaction in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module per_thread_signal_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] thread_id,
  input  wire logic [5:0]  signal_number,
  input  wire logic [31:0] mask_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      old_value,
  output logic [4:0]       signal_out
);
  import ptst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

  state_t      state;
  logic [2:0]  req_q;
  logic [31:0] id_q;
  logic [5:0]  sig_q;
  logic [31:0] set_q;
  logic        any_hit_q;
  logic        any_free_q;
  logic [31:0] old_mask_q;
  logic [31:0] old_pend_q;

  bcast_t          bc;
  link_t           chain [ENTRIES+1];
  logic [ENTRIES-1:0] sel_vec;

  logic        accept;
  logic        advance;
  logic        lookup_ok;
  logic        claim;
  logic        found;
  logic        do_write;
  logic [31:0] new_id;
  logic [31:0] new_mask;
  logic [31:0] new_pending;
  logic [1:0]  status_next;
  logic [31:0] old_value_next;
  logic [4:0]  signal_out_next;
  logic [31:0] take_hit;
  logic [31:0] low_bit;
  logic [4:0]  low_idx;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign advance  = (state == S_WRITE) && (!out_valid || !out_stall);

  // Requests that look up an entry; thread id zero does not, nor deliver of signal zero or above 31.
  assign lookup_ok = (id_q != 32'd0) &&
                     ((req_q != REQ_DELIVER) || ((sig_q != 6'd0) && !sig_q[5]));
  assign claim     = lookup_ok && (req_q != REQ_RELEASE);
  assign found     = any_hit_q || (claim && any_free_q);

  always_comb begin
    bc.lookup      = accept;
    bc.lookup_id   = thread_id;
    bc.select      = (state == S_READ);
    bc.claim       = claim;
    bc.any_hit     = any_hit_q;
    bc.wr_en       = advance && do_write;
    bc.new_id      = new_id;
    bc.new_mask    = new_mask;
    bc.new_pending = new_pending;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ptst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bc       (bc),
      .link_in  (chain[g]),
      .link_out (chain[g+1]),
      .sel      (sel_vec[g])
    );
  end

  // Lowest selected pending signal, bit 0 excluded.
  assign take_hit = set_q & old_pend_q & 32'hFFFF_FFFE;
  assign low_bit  = take_hit & (~take_hit + 32'd1);

  always_comb begin
    low_idx = 5'd0;
    for (int i = 1; i <= SIG_LAST; i++) begin
      low_idx = low_idx | (low_bit[i] ? 5'(i) : 5'd0);
    end
  end

  always_comb begin
    status_next     = ST_OK;
    old_value_next  = 32'd0;
    signal_out_next = 5'd0;
    do_write        = 1'b0;
    new_id          = id_q;
    new_mask        = old_mask_q;
    new_pending     = old_pend_q;
    if (req_q == REQ_DELIVER) begin
      if (sig_q[5]) begin
        status_next = ST_INVALID;
      end else if (sig_q == 6'd0) begin
        status_next = ST_OK;
      end else if (id_q == 32'd0) begin
        status_next = ST_INVALID;
      end else if (!found) begin
        status_next = ST_FULL;
      end else begin
        do_write    = 1'b1;
        new_pending = old_pend_q | (32'd1 << sig_q[4:0]);
      end
    end else if (id_q == 32'd0) begin
      status_next = ST_INVALID;
    end else if (req_q == REQ_RELEASE) begin
      do_write    = any_hit_q;
      new_id      = 32'd0;
      new_mask    = 32'd0;
      new_pending = 32'd0;
    end else if (!found) begin
      status_next = ST_FULL;
    end else begin
      do_write = 1'b1;
      case (req_q)
        REQ_BLOCK: begin
          old_value_next = old_mask_q;
          new_mask       = old_mask_q | set_q;
        end
        REQ_UNBLOCK: begin
          old_value_next = old_mask_q;
          new_mask       = old_mask_q & ~set_q;
        end
        REQ_SET_MASK: begin
          old_value_next = old_mask_q;
          new_mask       = set_q;
        end
        REQ_READ_MASK: begin
          old_value_next = old_mask_q;
        end
        REQ_TAKE: begin
          if (low_bit != 32'd0) begin
            signal_out_next = low_idx;
            new_pending     = old_pend_q & ~low_bit;
          end else begin
            status_next = ST_NONE;
          end
        end
        default: begin
          old_value_next = old_pend_q & old_mask_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      any_hit_q  <= 1'b0;
      any_free_q <= 1'b0;
    end else begin
      // Load a new result, or drop the old one once it is taken.
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            any_hit_q  <= chain[ENTRIES].hit;
            any_free_q <= chain[ENTRIES].free;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request, readout and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_type;
      id_q  <= thread_id;
      sig_q <= signal_number;
      set_q <= mask_value;
    end
    if (state == S_READ) begin
      old_mask_q <= chain[ENTRIES].mask;
      old_pend_q <= chain[ENTRIES].pending;
    end
    if (advance) begin
      status     <= status_next;
      old_value  <= old_value_next;
      signal_out <= signal_out_next;
    end
  end

  a_one_sel: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $onehot0(sel_vec))
    else $error("more than one entry selected");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted transaction did not start readout");

  a_result_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WRITE))
    else $error("result appeared without write-back");

  a_zero_id_no_hit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) && (id_q == 32'd0)) |-> !any_hit_q)
    else $error("thread id zero matched an entry");

endmodule

`default_nettype wire
